>>> hdl/bfac_pkg.sv
// Shared types, codes and helpers for the blocking fully associative cache.
`timescale 1ns / 1ps

package bfac_pkg;

    localparam int DEF_ENTRIES    = 8;
    localparam int DEF_LINE_BYTES = 8;
    localparam int DEF_ADDR_BITS  = 32;
    localparam int PORTS          = 4;

    localparam int CMD_W   = 2;
    localparam int PORT_W  = 2;
    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 64;
    localparam int MASK_W  = 8;
    localparam int KIND_W  = 3;
    localparam int LFSR_W  = 16;

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_RESP    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FETCH   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WB      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BUSY    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NO_MISS = 3'd4;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_INIT = 16'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PORT_W-1:0] port_id;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic [MASK_W-1:0] byte_mask;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PORT_W-1:0] port_id_out;
        logic [ADDR_W-1:0] line_address;
        logic [DATA_W-1:0] line_data;
        logic              was_hit;
        logic              last;
    } rsp_t;

    // Galois, right shift
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] sh;
        sh = s >> 1;
        return s[0] ? (sh ^ LFSR_TAPS) : sh;
    endfunction

endpackage

>>> hdl/blocking_fully_assoc_cache.sv
// Top level of the blocking fully associative write-allocate cache.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/ready    | req_t: command, port_id, address, data, byte_mask
//  rsp     | out | rsp_valid/ready    | rsp_t: kind, port_id_out, line_address, line_data, ...
//  cfg     | in  | cfg_we             | cfg_wdata: replacement seed, reloads the LFSR
//
// One item per cycle while the input stage is not held. An item is registered,
// then looked up against all tags in parallel, and its zero, one or two results
// are written into a 4-deep output queue, which drives rsp from its read slot.
// The input stage holds while the queue has fewer than two free slots.
// Reset clears line valid bits, the pending miss and the queue; LFSR = 1.
`timescale 1ns / 1ps

module blocking_fully_assoc_cache
    import bfac_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int LINE_BYTES = DEF_LINE_BYTES,
    parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              cfg_we,
    input  logic [LFSR_W-1:0] cfg_wdata
);

    localparam int AW  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int LW  = 8 * LINE_BYTES;
    localparam int IW  = $clog2(ENTRIES);
    localparam int OW  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int QD  = 4;
    localparam int QPW = 2;

    function automatic logic [LW-1:0] merge(input logic [LW-1:0] line,
                                            input logic [LW-1:0] bytes,
                                            input logic [LINE_BYTES-1:0] mask);
        logic [LW-1:0] res;
        res = line;
        for (int i = 0; i < LINE_BYTES; i++)
        begin
            if (mask[i])
            begin
                res[8*i +: 8] = bytes[8*i +: 8];
            end
        end
        return res;
    endfunction

    // input stage
    req_t                    req_reg;
    logic                    req_vld_reg;
    logic                    proc;

    // cache state
    logic [AW-1:0]           tag_reg   [ENTRIES];
    logic [LW-1:0]           line_reg  [ENTRIES];
    logic [ENTRIES-1:0]      valid_reg;
    logic                    pend_vld_reg;
    logic                    pend_wr_reg;
    logic [PORT_W-1:0]       pend_port_reg;
    logic [AW-1:0]           pend_addr_reg;
    logic [LW-1:0]           pend_bytes_reg;
    logic [LINE_BYTES-1:0]   pend_mask_reg;
    logic [LFSR_W-1:0]       lfsr_reg;

    // output queue
    rsp_t                    q_reg [QD];
    logic [QPW-1:0]          q_wp_reg;
    logic [QPW-1:0]          q_rp_reg;
    logic [QPW:0]            q_cnt_reg;

    // lookup
    logic [AW-1:0]           addr_cut;
    logic [OW-1:0]           offset;
    logic [AW-1:0]           line_addr;
    logic [AW-1:0]           key;
    logic [ENTRIES-1:0]      match;
    logic                    hit;
    logic [IW-1:0]           hit_idx;
    logic                    has_free;
    logic [IW-1:0]           free_idx;
    logic [LFSR_W-1:0]       lfsr_nx;
    logic [IW-1:0]           victim_idx;
    logic                    need_wb;
    logic [IW-1:0]           sel_idx;
    logic [LW-1:0]           sel_line;
    logic [AW-1:0]           sel_tag;
    logic [LW-1:0]           fill_line;
    logic                    port_ok;

    // per-item actions
    rsp_t                    r0;
    rsp_t                    r1;
    logic [1:0]              n_res;
    logic                    line_we;
    logic [LW-1:0]           line_wdata;
    logic                    tag_we;
    logic                    pend_set;
    logic                    pend_clr;
    logic                    lfsr_adv;

    assign proc      = req_vld_reg && (q_cnt_reg <= (QPW+1)'(QD - 2));
    assign req_ready = !req_vld_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            req_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            req_reg <= req;
        end
    end

    assign addr_cut = req_reg.address[AW-1:0];

    bfac_mod #(
        .WIDTH   (AW),
        .DIVISOR (LINE_BYTES)
    ) u_align (
        .val (addr_cut),
        .rem (offset)
    );

    assign line_addr = addr_cut - AW'(offset);
    assign key       = (req_reg.command == CMD_FILL) ? pend_addr_reg : line_addr;
    assign port_ok   = 32'(req_reg.port_id) < 32'(PORTS);

    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (tag_reg[i] == key);
            if (match[i])
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                has_free = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign lfsr_nx = lfsr_step(lfsr_reg);

    bfac_mod #(
        .WIDTH   (LFSR_W),
        .DIVISOR (ENTRIES)
    ) u_victim (
        .val (lfsr_nx),
        .rem (victim_idx)
    );

    assign need_wb = !hit && !has_free;

    always_comb
    begin
        if (req_reg.command != CMD_FILL)
        begin
            sel_idx = hit_idx;
        end
        else if (hit)
        begin
            sel_idx = hit_idx;
        end
        else if (has_free)
        begin
            sel_idx = free_idx;
        end
        else
        begin
            sel_idx = victim_idx;
        end
    end

    assign sel_line  = line_reg[sel_idx];
    assign sel_tag   = tag_reg[sel_idx];
    assign fill_line = pend_wr_reg
                     ? merge(req_reg.data[LW-1:0], pend_bytes_reg, pend_mask_reg)
                     : req_reg.data[LW-1:0];

    always_comb
    begin
        r0         = '0;
        r1         = '0;
        n_res      = 2'd0;
        line_we    = 1'b0;
        line_wdata = fill_line;
        tag_we     = 1'b0;
        pend_set   = 1'b0;
        pend_clr   = 1'b0;
        lfsr_adv   = 1'b0;
        case (req_reg.command) inside
            CMD_READ, CMD_WRITE:
            begin
                if (port_ok)
                begin
                    n_res = 2'd1;
                    if (pend_vld_reg)
                    begin
                        r0.kind        = KIND_BUSY;
                        r0.port_id_out = req_reg.port_id;
                    end
                    else if (hit)
                    begin
                        r0.kind         = KIND_RESP;
                        r0.port_id_out  = req_reg.port_id;
                        r0.line_address = ADDR_W'(line_addr);
                        r0.was_hit      = 1'b1;
                        if (req_reg.command == CMD_WRITE)
                        begin
                            line_we    = 1'b1;
                            line_wdata = merge(sel_line, req_reg.data[LW-1:0],
                                               req_reg.byte_mask[LINE_BYTES-1:0]);
                        end
                        else
                        begin
                            r0.line_data = DATA_W'(sel_line);
                        end
                    end
                    else
                    begin
                        pend_set        = 1'b1;
                        r0.kind         = KIND_FETCH;
                        r0.line_address = ADDR_W'(line_addr);
                    end
                end
            end
            CMD_FILL:
            begin
                if (!pend_vld_reg)
                begin
                    n_res   = 2'd1;
                    r0.kind = KIND_NO_MISS;
                end
                else
                begin
                    line_we  = 1'b1;
                    tag_we   = 1'b1;
                    pend_clr = 1'b1;
                    r1.kind         = KIND_RESP;
                    r1.port_id_out  = pend_port_reg;
                    r1.line_address = ADDR_W'(pend_addr_reg);
                    r1.line_data    = pend_wr_reg ? '0 : DATA_W'(fill_line);
                    if (need_wb)
                    begin
                        lfsr_adv        = 1'b1;
                        n_res           = 2'd2;
                        r0.kind         = KIND_WB;
                        r0.line_address = ADDR_W'(sel_tag);
                        r0.line_data    = DATA_W'(sel_line);
                    end
                    else
                    begin
                        n_res = 2'd1;
                        r0    = r1;
                    end
                end
            end
            default:
            begin
                n_res = 2'd0;
            end
        endcase
        r0.last = (n_res == 2'd1);
        r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            pend_vld_reg <= 1'b0;
            lfsr_reg     <= LFSR_INIT;
        end
        else
        begin
            if (proc && tag_we)
            begin
                valid_reg[sel_idx] <= 1'b1;
            end
            if (proc && pend_set)
            begin
                pend_vld_reg <= 1'b1;
            end
            else if (proc && pend_clr)
            begin
                pend_vld_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                lfsr_reg <= (cfg_wdata == '0) ? LFSR_INIT : cfg_wdata;
            end
            else if (proc && lfsr_adv)
            begin
                lfsr_reg <= lfsr_nx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && line_we)
        begin
            line_reg[sel_idx] <= line_wdata;
        end
        if (proc && tag_we)
        begin
            tag_reg[sel_idx] <= pend_addr_reg;
        end
        if (proc && pend_set)
        begin
            pend_wr_reg    <= (req_reg.command == CMD_WRITE);
            pend_port_reg  <= req_reg.port_id;
            pend_addr_reg  <= line_addr;
            pend_bytes_reg <= req_reg.data[LW-1:0];
            pend_mask_reg  <= req_reg.byte_mask[LINE_BYTES-1:0];
        end
    end

    // output queue
    logic q_pop;
    logic [QPW:0] q_push_n;

    assign q_pop     = rsp_valid && rsp_ready;
    assign q_push_n  = proc ? (QPW+1)'(n_res) : '0;
    assign rsp_valid = (q_cnt_reg != '0);
    assign rsp       = q_reg[q_rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= '0;
            q_rp_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_wp_reg  <= q_wp_reg + QPW'(q_push_n);
            q_rp_reg  <= q_rp_reg + QPW'(q_pop);
            q_cnt_reg <= q_cnt_reg + q_push_n - (QPW+1)'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && (n_res != 2'd0))
        begin
            q_reg[q_wp_reg] <= r0;
        end
        if (proc && (n_res == 2'd2))
        begin
            q_reg[q_wp_reg + QPW'(1)] <= r1;
        end
    end

endmodule

>>> hdl/bfac_mod.sv
// Remainder of an unsigned value by a small elaboration-time constant.
`timescale 1ns / 1ps

module bfac_mod #(
    parameter int WIDTH   = 16,
    parameter int DIVISOR = 8
) (
    input  logic [WIDTH-1:0]                                  val,
    output logic [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0] rem
);

    localparam int NIB  = (WIDTH + 3) / 4;
    localparam int RW   = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
    localparam int SMAX = NIB * (DIVISOR - 1);
    localparam int SW   = (SMAX > 0) ? $clog2(SMAX + 1) : 1;

    logic [4*NIB-1:0] val_pad;
    logic [RW-1:0]    nib_res [NIB][16];
    logic [RW-1:0]    sum_res [2**SW];
    logic [SW-1:0]    acc;

    assign val_pad = (4*NIB)'(val);

    // residue of each nibble at its weight
    for (genvar j = 0; j < NIB; j++)
    begin : g_nib
        for (genvar n = 0; n < 16; n++)
        begin : g_val
            localparam longint unsigned RES = (64'(n) << (4*j)) % DIVISOR;
            assign nib_res[j][n] = RW'(RES);
        end
    end

    for (genvar s = 0; s < 2**SW; s++)
    begin : g_sum
        localparam int RES = s % DIVISOR;
        assign sum_res[s] = RW'(RES);
    end

    always_comb
    begin
        acc = '0;
        for (int j = 0; j < NIB; j++)
        begin
            acc = acc + SW'(nib_res[j][val_pad[4*j +: 4]]);
        end
    end

    assign rem = sum_res[acc];

endmodule
